/* hw/rtl/dgsp_pkg.sv */
`timescale 1ns / 1ps
package dgsp_pkg;

   localparam int NODES_DEF = 16;
   localparam int NODE_W    = 4;
   localparam int WEIGHT_W  = 14;
   localparam int DIST_W    = 18;
   localparam int CNT_W     = 5;
   localparam int STACK_D   = 16;

   localparam logic [WEIGHT_W-1:0] INF_WEIGHT = 14'd9999;
   localparam logic [CNT_W-1:0]    NC_RESET   = 5'd16;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_RUN  = 1'b1;

   localparam logic REG_NODE_COUNT = 1'b0;

   typedef struct packed {
      logic                action;
      logic [NODE_W-1:0]   first_node;
      logic [NODE_W-1:0]   second_node;
      logic [WEIGHT_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] path_node;
      logic [DIST_W-1:0] total_distance;
      logic              last;
   } rsp_type;

   // one node's search record
   typedef struct packed {
      logic [DIST_W-1:0] d;
      logic [NODE_W-1:0] p;
      logic              v;
   } rec_type;

endpackage

/* hw/rtl/dgsp_cell.sv */
`timescale 1ns / 1ps
module dgsp_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  dgsp_pkg::rec_type rec_in,
   output dgsp_pkg::rec_type rec_out
);
   import dgsp_pkg::*;

   rec_type rec_ff;
   rec_type rec_nx_in;

   // take the neighbor's record on a shift, otherwise hold
   always_comb begin
      rec_nx_in = shift_en ? rec_in : rec_ff;
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_nx_in;
   end

   assign rec_out = rec_ff;

endmodule

/* hw/rtl/dgsp_weight_mem.sv */
`timescale 1ns / 1ps
module dgsp_weight_mem #(
   parameter int NODES = dgsp_pkg::NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              we,
   input  logic [$clog2(NODES*NODES)-1:0]    waddr,
   input  logic [dgsp_pkg::WEIGHT_W-1:0]     wdata,
   input  logic [$clog2(NODES*NODES)-1:0]    raddr,
   output logic [dgsp_pkg::WEIGHT_W-1:0]     rdata,
   output logic                              clearing
);
   import dgsp_pkg::*;

   localparam int DEPTH = NODES * NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WEIGHT_W-1:0] mem [DEPTH];
   logic [WEIGHT_W-1:0] rdata_ff;
   logic [CW-1:0]       clr_ff;
   logic [CW-1:0]       clr_in;

   assign clearing = (clr_ff != CW'(DEPTH));

   always_comb begin
      clr_in = clearing ? clr_ff + 1'b1 : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // sweep zeros after reset, then take load writes
   always_ff @(posedge clock) begin
      if (clearing) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/dense_graph_shortest_path_core.sv */
`timescale 1ns / 1ps
// Load word: one memory write per direction of the edge, the reverse one from ST_LOAD2.
// Query word: up to n-1 passes, each with one weight read per cycle from the
// weight memory while the node records rotate once through the cell ring, then
// a path walk from the destination back toward the source and one result per cycle.
// Results appear on rsp_valid for one cycle each; the receiver cannot stall.
// After reset the weight memory is cleared to zero; busy is high meanwhile.
module dense_graph_shortest_path_core #(
   parameter int NODES = dgsp_pkg::NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dgsp_pkg::req_type req_payload,
   output logic              rsp_valid,
   output dgsp_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import dgsp_pkg::*;

   localparam int IDW  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int AW   = $clog2(NODES * NODES);
   localparam int PCW  = $clog2(NODES + 1);
   localparam int NLIM = (NODES < 16) ? NODES : 16;
   localparam int KW   = ((IDW > CNT_W) ? IDW : CNT_W) + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD2 = 3'd1;
   localparam logic [2:0] ST_PASS  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   function automatic logic [AW-1:0] mat_addr(input logic [NODE_W-1:0] r,
                                              input logic [IDW-1:0] c);
      return AW'(AW'(r) * AW'(NODES)) + AW'(c);
   endfunction

   // control registers
   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    node_count_ff, node_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   // datapath registers
   rsp_type             rsp_ff, rsp_in;
   logic [NODE_W-1:0]   src_ff, src_in, dst_ff, dst_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [NODE_W-1:0]   row_ff, row_in, pick_ff, pick_in;
   logic [WEIGHT_W-1:0] mind_ff, mind_in;
   logic                init_ff, init_in;
   logic [PCW-1:0]      pcnt_ff, pcnt_in;
   logic [CNT_W-1:0]    round_ff, round_in;
   logic [WEIGHT_W-1:0] amin_ff, amin_in;
   logic [NODE_W-1:0]   apick_ff, apick_in;
   logic                afound_ff, afound_in;
   logic [NODE_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [NODE_W-1:0]   stack_ff [STACK_D];

   logic                mem_we, mem_clr;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [WEIGHT_W-1:0] mem_wdata, mem_rdata;

   rec_type             recs [NODES];
   rec_type             proc;
   logic                shift_en;
   logic [CNT_W-1:0]    n_use;
   logic                accept, cfg_wr, in_bounds;
   logic [WEIGHT_W-1:0] sat_w, cost;
   logic [IDW-1:0]      head_id;
   logic [DIST_W-1:0]   via;
   logic [CNT_W-1:0]    r_cur;
   rec_type             jrec;
   logic                push_en;

   assign accept = start && !busy;
   assign busy   = mem_clr || (state_ff != ST_IDLE);
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT);
   assign pready = 1'b1;
   assign prdata = 32'(node_count_ff);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (node_count_ff < 5'd2) begin
         n_use = 5'd2;
      end else if (node_count_ff > CNT_W'(NLIM)) begin
         n_use = CNT_W'(NLIM);
      end else begin
         n_use = node_count_ff;
      end
   end

   assign sat_w = (req_payload.edge_weight > INF_WEIGHT) ? INF_WEIGHT
                                                         : req_payload.edge_weight;
   assign in_bounds = (int'(req_payload.first_node) < NODES) &&
                      (int'(req_payload.second_node) < NODES);

   // weight memory port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = mat_addr(req_payload.first_node, IDW'(req_payload.second_node));
      mem_wdata = sat_w;
      if (state_ff == ST_LOAD2) begin
         mem_we    = 1'b1;
         mem_waddr = mat_addr(dst_ff, IDW'(src_ff));
         mem_wdata = w_ff;
      end else if (state_ff == ST_IDLE) begin
         mem_we = accept && (req_payload.action == ACT_LOAD) && in_bounds;
      end
   end

   assign mem_raddr = mat_addr(row_ff, IDW'(pcnt_ff));

   dgsp_weight_mem #(.NODES(NODES)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata),
      .raddr    (mem_raddr),
      .rdata    (mem_rdata),
      .clearing (mem_clr)
   );

   // ring of node records; the head record is updated and re-enters at the tail
   assign shift_en = (state_ff == ST_PASS) && (pcnt_ff != '0);

   for (genvar k = 0; k < NODES; k++) begin : g_cell
      if (k == NODES - 1) begin : g_tail
         dgsp_cell u_cell (.clock(clock), .shift_en(shift_en), .rec_in(proc),
                           .rec_out(recs[k]));
      end else begin : g_body
         dgsp_cell u_cell (.clock(clock), .shift_en(shift_en), .rec_in(recs[k+1]),
                           .rec_out(recs[k]));
      end
   end

   assign head_id = IDW'(pcnt_ff - 1'b1);
   assign cost    = (mem_rdata == '0) ? INF_WEIGHT : mem_rdata;
   assign via     = DIST_W'(mind_ff) + DIST_W'(cost);

   always_comb begin
      proc = recs[0];
      if (init_ff) begin
         proc.d = (KW'(head_id) == KW'(src_ff)) ? '0 : DIST_W'(cost);
         proc.p = src_ff;
         proc.v = (KW'(head_id) == KW'(src_ff)) || (KW'(head_id) >= KW'(n_use));
      end else if (!recs[0].v) begin
         if (KW'(head_id) == KW'(pick_ff)) begin
            proc.v = 1'b1;
         end else if (via < recs[0].d) begin
            proc.d = via;
            proc.p = pick_ff;
         end
      end
   end

   assign r_cur   = init_ff ? CNT_W'(1) : round_ff;
   assign jrec    = recs[IDW'(j_ff)];
   assign push_en = (state_ff == ST_WALK);

   always_comb begin
      state_in      = state_ff;
      node_count_in = cfg_wr ? CNT_W'(pwdata) : node_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      w_in          = w_ff;
      row_in        = row_ff;
      pick_in       = pick_ff;
      mind_in       = mind_ff;
      init_in       = init_ff;
      pcnt_in       = pcnt_ff;
      round_in      = round_ff;
      amin_in       = amin_ff;
      apick_in      = apick_ff;
      afound_in     = afound_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      dist_in       = dist_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               src_in = req_payload.first_node;
               dst_in = req_payload.second_node;
               w_in   = sat_w;
               if (req_payload.action == ACT_LOAD) begin
                  if (in_bounds) begin
                     state_in = ST_LOAD2;
                  end
               end else if (CNT_W'(req_payload.first_node) < n_use &&
                            CNT_W'(req_payload.second_node) < n_use) begin
                  if (req_payload.first_node == req_payload.second_node) begin
                     rsp_valid_in          = 1'b1;
                     rsp_in.path_node      = req_payload.first_node;
                     rsp_in.total_distance = '0;
                     rsp_in.last           = 1'b1;
                  end else begin
                     state_in  = ST_PASS;
                     init_in   = 1'b1;
                     row_in    = req_payload.first_node;
                     pcnt_in   = '0;
                     amin_in   = INF_WEIGHT;
                     afound_in = 1'b0;
                  end
               end
            end
         end
         ST_LOAD2: begin
            state_in = ST_IDLE;
         end
         ST_PASS: begin
            if (pcnt_ff != '0 && !proc.v && proc.d < DIST_W'(amin_ff)) begin
               amin_in   = WEIGHT_W'(proc.d);
               apick_in  = NODE_W'(head_id);
               afound_in = 1'b1;
            end
            pcnt_in = pcnt_ff + 1'b1;
            if (pcnt_ff == PCW'(NODES)) begin
               if ((6'(r_cur) + 6'd1 < 6'(n_use)) && afound_in) begin
                  row_in    = apick_in;
                  pick_in   = apick_in;
                  mind_in   = amin_in;
                  init_in   = 1'b0;
                  round_in  = r_cur + 1'b1;
                  pcnt_in   = '0;
                  amin_in   = INF_WEIGHT;
                  afound_in = 1'b0;
               end else begin
                  state_in = ST_WALK;
                  j_in     = dst_ff;
                  cnt_in   = '0;
               end
            end
         end
         ST_WALK: begin
            if (cnt_ff == '0) begin
               dist_in = jrec.d;
            end
            cnt_in = cnt_ff + 1'b1;
            j_in   = jrec.p;
            if (jrec.p == src_ff || !(6'(cnt_in) + 6'd1 < 6'(n_use))) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in          = 1'b1;
            rsp_in.total_distance = dist_ff;
            if (cnt_ff != '0) begin
               rsp_in.path_node = stack_ff[4'(cnt_ff - 1'b1)];
               rsp_in.last      = 1'b0;
               cnt_in           = cnt_ff - 1'b1;
            end else begin
               rsp_in.path_node = dst_ff;
               rsp_in.last      = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NC_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      w_ff      <= w_in;
      row_ff    <= row_in;
      pick_ff   <= pick_in;
      mind_ff   <= mind_in;
      init_ff   <= init_in;
      pcnt_ff   <= pcnt_in;
      round_ff  <= round_in;
      amin_ff   <= amin_in;
      apick_ff  <= apick_in;
      afound_ff <= afound_in;
      j_ff      <= j_in;
      cnt_ff    <= cnt_in;
      dist_ff   <= dist_in;
      if (push_en) begin
         stack_ff[cnt_ff[3:0]] <= jrec.p;
      end
   end

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      mem_clr |-> !rsp_valid_ff)
      else $error("result during weight clear");

   a_load_two_cycles: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD2 |=> state_ff == ST_IDLE)
      else $error("load did not finish");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PASS |-> pcnt_ff <= PCW'(NODES))
      else $error("pass counter overran");

   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && cnt_ff == '0) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("path ended without last word");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import dgsp_pkg::*;

   localparam int  N_MAX      = 16;
   localparam int  CYCLE_CAP  = 3000000;
   localparam int  DRAIN_WAIT = 400;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   dense_graph_shortest_path_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // model state
   logic [WEIGHT_W-1:0] edge_wt [N_MAX][N_MAX];
   int                  node_limit;
   rsp_type             path_words_due[$];
   int                  mismatches;
   int                  cycle_no;
   int                  idle_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (cycle_no > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic note_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d at cycle %0d", what, want, got, cycle_no);
   endtask

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (path_words_due.size() == 0) begin
            note_mismatch("unexpected word node", -1, int'(rsp_payload.path_node));
         end else begin
            rsp_type want;
            want = path_words_due.pop_front();
            if (rsp_payload.path_node !== want.path_node)
               note_mismatch("path_node", int'(want.path_node),
                             int'(rsp_payload.path_node));
            if (rsp_payload.total_distance !== want.total_distance)
               note_mismatch("total_distance", int'(want.total_distance),
                             int'(rsp_payload.total_distance));
            if (rsp_payload.last !== want.last)
               note_mismatch("last", int'(want.last), int'(rsp_payload.last));
         end
      end
   end

   function automatic int hop_cost(int a, int b);
      return (edge_wt[a][b] == 0) ? int'(INF_WEIGHT) : int'(edge_wt[a][b]);
   endfunction

   // apply a word to the model and return the path words it produces
   function automatic void shortest_path(input req_type r, output rsp_type words[$]);
      int      best [N_MAX];
      int      prev [N_MAX];
      bit      seen [N_MAX];
      int      stk  [N_MAX];
      int      a, b, w, cnt, j, pick, mind;
      bit      found;
      rsp_type word;
      words = {};
      a = int'(r.first_node);
      b = int'(r.second_node);
      w = int'(r.edge_weight);
      if (r.action == ACT_LOAD) begin
         if (w > int'(INF_WEIGHT)) w = int'(INF_WEIGHT);
         edge_wt[a][b] = WEIGHT_W'(w);
         edge_wt[b][a] = WEIGHT_W'(w);
         return;
      end
      if (a >= node_limit || b >= node_limit) return;
      if (a == b) begin
         word.path_node = NODE_W'(a);
         word.total_distance = '0;
         word.last = 1'b1;
         words.push_back(word);
         return;
      end
      for (int i = 0; i < node_limit; i++) begin
         best[i] = hop_cost(a, i);
         prev[i] = a;
         seen[i] = 1'b0;
      end
      best[a] = 0;
      seen[a] = 1'b1;
      for (int rnd = 1; rnd + 1 < node_limit; rnd++) begin
         mind = int'(INF_WEIGHT);
         pick = 0;
         found = 1'b0;
         for (int i = 0; i < node_limit; i++)
            if (!seen[i] && best[i] < mind) begin
               mind = best[i];
               pick = i;
               found = 1'b1;
            end
         if (!found) break;
         seen[pick] = 1'b1;
         for (int i = 0; i < node_limit; i++)
            if (!seen[i] && mind + hop_cost(pick, i) < best[i]) begin
               best[i] = mind + hop_cost(pick, i);
               prev[i] = pick;
            end
      end
      cnt = 0;
      j = b;
      do begin
         j = prev[j];
         stk[cnt] = j;
         cnt++;
      end while (j != a && cnt + 1 < node_limit);
      while (cnt > 0) begin
         cnt--;
         word.path_node = NODE_W'(stk[cnt]);
         word.total_distance = DIST_W'(best[b]);
         word.last = 1'b0;
         words.push_back(word);
      end
      word.path_node = NODE_W'(b);
      word.total_distance = DIST_W'(best[b]);
      word.last = 1'b1;
      words.push_back(word);
   endfunction

   // hold start until the word is taken; caller decides whether to drop start
   task automatic send_word(req_type r, int typed, int n_words, int exp_dist);
      rsp_type words[$];
      rsp_type word;
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!(start === 1'b1 && busy === 1'b0));
      shortest_path(r, words);
      if (typed) begin
         words = {};
         for (int k = 0; k < n_words; k++) begin
            word.path_node = (k == 0) ? r.first_node : r.second_node;
            word.total_distance = DIST_W'(exp_dist);
            word.last = (k == n_words - 1);
            words.push_back(word);
         end
      end
      foreach (words[k]) path_words_due.push_back(words[k]);
   endtask

   task automatic maybe_idle();
      if (int'($urandom_range(0, 99)) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // drop start, let all words drain and the block settle
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (path_words_due.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write_node_count(int v);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {REG_NODE_COUNT, 2'b00}; pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pwrite <= 1'b0; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[CNT_W-1:0] !== v[CNT_W-1:0])
         note_mismatch("node_count readback", v & 31, int'(prdata[CNT_W-1:0]));
      psel <= 1'b0; penable <= 1'b0;
      node_limit = v & 31;
      if (node_limit < 2) node_limit = 2;
      if (node_limit > N_MAX) node_limit = N_MAX;
      @(posedge clock);
   endtask

   function automatic req_type random_word(int n);
      req_type r;
      r.action = ($urandom_range(0, 99) < 55) ? ACT_LOAD : ACT_RUN;
      r.edge_weight = WEIGHT_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         r.first_node = NODE_W'($urandom);
         r.second_node = NODE_W'($urandom);
      end else begin
         r.first_node = NODE_W'($urandom_range(0, n - 1));
         r.second_node = NODE_W'($urandom_range(0, n - 1));
      end
      if (r.action == ACT_LOAD)
         case ($urandom_range(0, 9))
            0, 1: r.edge_weight = '0;
            2:    r.edge_weight = WEIGHT_W'($urandom);
            3:    r.edge_weight = INF_WEIGHT;
            default: r.edge_weight = WEIGHT_W'($urandom_range(1, 60));
         endcase
      return r;
   endfunction

   typedef struct {
      logic       act;
      int         a, b, w;
      int         typed, n_words, exp_dist;
   } step_row;

   step_row script[] = '{
      '{ACT_RUN,   3,  3,     0, 1, 1, 0},
      '{ACT_RUN,   0, 15,     0, 1, 2, 9999},
      '{ACT_LOAD,  0,  1,     5, 1, 0, 0},
      '{ACT_LOAD,  1,  2,     7, 1, 0, 0},
      '{ACT_LOAD,  2, 15, 16383, 1, 0, 0},
      '{ACT_RUN,   0, 15, 16383, 1, 2, 9999},
      '{ACT_LOAD,  2, 15,  9998, 1, 0, 0},
      '{ACT_LOAD,  4,  4,     3, 1, 0, 0},
      '{ACT_LOAD,  3, 14,     1, 1, 0, 0},
      '{ACT_LOAD, 14, 13,  9999, 1, 0, 0},
      '{ACT_LOAD,  0,  2,    20, 1, 0, 0},
      '{ACT_RUN,   0, 15,     0, 0, 0, 0},
      '{ACT_RUN,  15,  0,     0, 0, 0, 0},
      '{ACT_RUN,   0,  2,     0, 0, 0, 0},
      '{ACT_RUN,   3, 13,     0, 1, 2, 9999},
      '{ACT_RUN,   4,  4,     0, 1, 1, 0},
      '{ACT_RUN,  15, 15,     0, 1, 1, 0},
      '{ACT_LOAD, 15,  0,     0, 1, 0, 0},
      '{ACT_RUN,   1, 14,     0, 0, 0, 0},
      '{ACT_RUN,   2,  1,     0, 0, 0, 0}
   };

   int phase_nc[] = '{2, 31, 0, 5, 16, 1, 9, 16};

   initial begin
      req_type r;
      int      per_phase;
      reset = 1'b1; start = 1'b0; req_payload = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cycle_no = 0; mismatches = 0; node_limit = int'(NC_RESET); idle_pct = 0;
      foreach (edge_wt[i, j]) edge_wt[i][j] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         r.action = script[i].act;
         r.first_node = NODE_W'(script[i].a);
         r.second_node = NODE_W'(script[i].b);
         r.edge_weight = WEIGHT_W'(script[i].w);
         send_word(r, script[i].typed, script[i].n_words, script[i].exp_dist);
         if (i % 3 == 2) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      quiesce();

      per_phase = 220 / phase_nc.size();
      foreach (phase_nc[p]) begin
         csr_write_node_count(phase_nc[p]);
         idle_pct = (p < 3) ? 38 : (p < 6) ? 47 : 0;
         for (int k = 0; k < per_phase; k++) begin
            send_word(random_word(node_limit), 0, 0, 0);
            if (k == per_phase / 2) begin
               // hold off until every pending word is out
               start <= 1'b0;
               @(posedge clock);
               while (path_words_due.size() != 0) @(posedge clock);
            end else begin
               maybe_idle();
            end
         end
         quiesce();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && path_words_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/dgsp_pkg.sv
hw/rtl/dgsp_cell.sv
hw/rtl/dgsp_weight_mem.sv
hw/rtl/dense_graph_shortest_path_core.sv
test/tb_top.sv
